@@ hdl/nlp_pkg.sv @@
// ----------------------------------------------------------------------------
// nlp_pkg
// Types, character codes and digit decode shared by the numeric literal parser.
// ----------------------------------------------------------------------------
package nlp_pkg;

   localparam int MAX_TOKEN_LEN_DEF = 64;

   // character codes
   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_1    = 8'h31;
   localparam logic [7:0] CH_7    = 8'h37;
   localparam logic [7:0] CH_9    = 8'h39;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_B    = 8'h62;
   localparam logic [7:0] CH_N    = 8'h6e;
   localparam logic [7:0] CH_X    = 8'h78;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START,
      PH_DEC,
      PH_ZERO,
      PH_BIN,
      PH_OCT,
      PH_HEX,
      PH_HASH,
      PH_HASH0,
      PH_GBIN,
      PH_GHEX
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_BADDEC,
      ST_BADBIN,
      ST_BADOCT,
      ST_BADHEX,
      ST_BADPFX
   } status_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       first_of_token;
      logic [6:0] token_length;
   } req_type;

   typedef struct packed {
      logic [15:0] value;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      phase_type phase;
      logic      skip_rest;
   } ctl_type;

   // {valid, value} of a hex digit character
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

@@ hdl/nlp_step.sv @@
// ----------------------------------------------------------------------------
// nlp_step
// Per-character parse logic: next parser state and the optional result.
// ----------------------------------------------------------------------------
module nlp_step #(
   parameter int MAX_TOKEN_LEN = nlp_pkg::MAX_TOKEN_LEN_DEF,
   parameter int PW            = $clog2(MAX_TOKEN_LEN + 1),
   parameter int BW            = PW + 1
) (
   input  nlp_pkg::req_type req,
   input  nlp_pkg::ctl_type ctl,
   input  logic [15:0]      acc,
   input  logic [PW-1:0]    pos,
   input  logic [PW-1:0]    len,
   input  logic [BW-1:0]    bound,
   output nlp_pkg::ctl_type ctl_next,
   output logic [15:0]      acc_next,
   output logic [PW-1:0]    pos_next,
   output logic [PW-1:0]    len_next,
   output logic [BW-1:0]    bound_next,
   output logic             res_valid,
   output nlp_pkg::rsp_type res
);
   import nlp_pkg::*;

   logic [PW-1:0] len_e;
   logic [PW-1:0] pos_e;
   logic [15:0]   acc_e;
   logic [BW-1:0] bound_e;
   logic          skip_e;
   logic          skip_n;
   phase_type     ph_e;
   phase_type     ph_n;
   logic          active;
   logic [PW-1:0] pos_inc;
   logic          last;
   logic [4:0]    hd;
   logic [3:0]    dig;
   logic          dig_ok;
   logic [15:0]   acc_mac;
   logic          grp_end;
   logic [PW-1:0] digits;
   logic [BW-1:0] bound_bin0;
   logic [BW-1:0] bound_hex0;
   logic [7:0]    c;

   assign c = req.char_code;

   // a first character restarts the token
   always_comb begin
      if (req.first_of_token) begin
         if (32'(req.token_length) > MAX_TOKEN_LEN) begin
            len_e = PW'(MAX_TOKEN_LEN);
         end else begin
            len_e = PW'(req.token_length);
         end
         pos_e   = '0;
         acc_e   = '0;
         bound_e = '0;
         skip_e  = 1'b0;
         ph_e    = PH_START;
      end else begin
         len_e   = len;
         pos_e   = pos;
         acc_e   = acc;
         bound_e = bound;
         skip_e  = ctl.skip_rest;
         ph_e    = ctl.phase;
      end
   end

   assign active  = (ph_e != PH_IDLE) && !skip_e && (pos_e < len_e);
   assign pos_inc = pos_e + PW'(1);
   assign last    = (pos_inc == len_e);
   assign hd      = hex_digit(c);
   assign dig     = hd[3:0];
   assign grp_end = ((BW'(pos_e) - BW'(2)) == bound_e);

   // digit count after the three-character group prefix
   assign digits     = len_e - PW'(3);
   assign bound_bin0 = (digits == '0) ? '0 : BW'((digits - PW'(1)) & PW'(7)) + BW'(1);
   assign bound_hex0 = (digits == '0) ? '0 : BW'((digits - PW'(1)) & PW'(1)) + BW'(1);

   always_comb begin
      case (ph_e)
         PH_DEC:            dig_ok = hd[4] && (dig < 4'd10);
         PH_BIN, PH_GBIN:   dig_ok = hd[4] && (dig < 4'd2);
         PH_OCT:            dig_ok = hd[4] && (dig < 4'd8);
         PH_HEX, PH_GHEX:   dig_ok = hd[4];
         default:           dig_ok = 1'b0;
      endcase
   end

   // constant-radix shift-add
   always_comb begin
      case (ph_e)
         PH_DEC:            acc_mac = (acc_e << 3) + (acc_e << 1) + 16'(dig);
         PH_BIN, PH_GBIN:   acc_mac = (acc_e << 1) + 16'(dig);
         PH_OCT:            acc_mac = (acc_e << 3) + 16'(dig);
         PH_HEX, PH_GHEX:   acc_mac = (acc_e << 4) + 16'(dig);
         default:           acc_mac = acc_e;
      endcase
   end

   // next phase
   always_comb begin
      ph_n = ph_e;
      if (active) begin
         case (ph_e)
            PH_START: begin
               if (c inside {[CH_1:CH_9]}) begin
                  ph_n = PH_DEC;
               end else if (c == CH_0) begin
                  ph_n = PH_ZERO;
               end else if (c == CH_HASH) begin
                  ph_n = PH_HASH;
               end
            end
            PH_ZERO: begin
               if (c inside {CH_B, CH_N}) begin
                  ph_n = PH_BIN;
               end else if (c inside {[CH_0:CH_7]}) begin
                  ph_n = PH_OCT;
               end else if (c == CH_X) begin
                  ph_n = PH_HEX;
               end
            end
            PH_HASH: begin
               if (c == CH_0) begin
                  ph_n = PH_HASH0;
               end
            end
            PH_HASH0: begin
               if (c inside {CH_B, CH_N}) begin
                  ph_n = PH_GBIN;
               end else if (c == CH_X) begin
                  ph_n = PH_GHEX;
               end
            end
            default: ph_n = ph_e;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      acc_next   = acc_e;
      pos_next   = active ? pos_inc : pos_e;
      len_next   = len_e;
      bound_next = bound_e;
      res_valid  = 1'b0;
      res.value  = '0;
      res.status = ST_OK;
      skip_n     = skip_e;
      if (active) begin
         case (ph_e)
            PH_START: begin
               if (c inside {[CH_1:CH_9]}) begin
                  acc_next  = 16'(c - CH_0);
                  res_valid = last;
                  res.value = 16'(c - CH_0);
               end else if (c == CH_0) begin
                  acc_next  = '0;
                  res_valid = last;
               end else if (c != CH_HASH) begin
                  skip_n = 1'b1;
               end
            end
            PH_ZERO: begin
               if (c inside {CH_B, CH_N} || c == CH_X) begin
                  res_valid = last;
               end else if (c inside {[CH_0:CH_7]}) begin
                  acc_next  = 16'(c - CH_0);
                  res_valid = last;
                  res.value = 16'(c - CH_0);
               end else begin
                  skip_n     = 1'b1;
                  res_valid  = 1'b1;
                  res.status = ST_BADPFX;
               end
            end
            PH_DEC, PH_BIN, PH_OCT, PH_HEX: begin
               if (!dig_ok) begin
                  skip_n    = 1'b1;
                  res_valid = 1'b1;
                  case (ph_e)
                     PH_DEC:  res.status = ST_BADDEC;
                     PH_BIN:  res.status = ST_BADBIN;
                     PH_OCT:  res.status = ST_BADOCT;
                     default: res.status = ST_BADHEX;
                  endcase
               end else begin
                  acc_next  = acc_mac;
                  res_valid = last;
                  res.value = acc_mac;
               end
            end
            PH_HASH: begin
               if (c == CH_0) begin
                  // a token that is exactly the hash and zero
                  if (last) begin
                     skip_n     = 1'b1;
                     res_valid  = 1'b1;
                     res.status = ST_BADPFX;
                  end
               end else begin
                  skip_n = 1'b1;
               end
            end
            PH_HASH0: begin
               if (c inside {CH_B, CH_N}) begin
                  bound_next = bound_bin0;
                  acc_next   = '0;
                  res_valid  = last;
               end else if (c == CH_X) begin
                  bound_next = bound_hex0;
                  acc_next   = '0;
                  res_valid  = last;
               end else begin
                  skip_n     = 1'b1;
                  res_valid  = 1'b1;
                  res.status = ST_BADPFX;
               end
            end
            PH_GBIN, PH_GHEX: begin
               if (!dig_ok) begin
                  skip_n     = 1'b1;
                  res_valid  = 1'b1;
                  res.status = (ph_e == PH_GBIN) ? ST_BADBIN : ST_BADHEX;
               end else if (grp_end) begin
                  acc_next   = '0;
                  res_valid  = 1'b1;
                  res.value  = acc_mac;
                  bound_next = bound_e + ((ph_e == PH_GBIN) ? BW'(8) : BW'(2));
               end else begin
                  acc_next = acc_mac;
               end
            end
            default: skip_n = 1'b1;
         endcase
      end
   end

   assign ctl_next = '{phase: ph_n, skip_rest: skip_n};

endmodule

@@ hdl/nlp_out_buf.sv @@
// ----------------------------------------------------------------------------
// nlp_out_buf
// Two-entry result buffer between the parse stage and the result channel.
// ----------------------------------------------------------------------------
module nlp_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  nlp_pkg::rsp_type push_item,
   output logic             space,
   output logic             out_valid,
   input  logic             out_ready,
   output nlp_pkg::rsp_type out_item
);
   import nlp_pkg::*;

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign space     = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push)
      else $error("result pushed into full buffer");
   a_count_tracks_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("buffer count disagrees with pointers");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("buffer count did not grow on push");
`endif

endmodule

@@ hdl/numeric_literal_parser.sv @@
// ----------------------------------------------------------------------------
// numeric_literal_parser: one character per cycle while the buffer has space
// Throughput is one item per cycle, set by the combinational shift-add stage.
// Reset returns the parser to awaiting a first character and empties the buffer.
// ----------------------------------------------------------------------------
module numeric_literal_parser #(
   parameter int MAX_TOKEN_LEN = nlp_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nlp_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nlp_pkg::rsp_type rsp_item
);
   import nlp_pkg::*;

   localparam int PW = $clog2(MAX_TOKEN_LEN + 1);
   localparam int BW = PW + 1;

   ctl_type       ctl_ff;
   ctl_type       ctl_in;
   logic [15:0]   acc_ff;
   logic [15:0]   acc_in;
   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic [PW-1:0] len_ff;
   logic [PW-1:0] len_in;
   logic [BW-1:0] bound_ff;
   logic [BW-1:0] bound_in;
   logic          res_valid;
   rsp_type       res;
   logic          accept;
   logic          space;

   assign req_ready = space;
   assign accept    = req_valid && req_ready;

   nlp_step #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
      .PW            (PW),
      .BW            (BW)
   ) u_step (
      .req        (req_item),
      .ctl        (ctl_ff),
      .acc        (acc_ff),
      .pos        (pos_ff),
      .len        (len_ff),
      .bound      (bound_ff),
      .ctl_next   (ctl_in),
      .acc_next   (acc_in),
      .pos_next   (pos_in),
      .len_next   (len_in),
      .bound_next (bound_in),
      .res_valid  (res_valid),
      .res        (res)
   );

   nlp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && res_valid),
      .push_item (res),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '{phase: PH_IDLE, skip_rest: 1'b0};
         acc_ff   <= '0;
         pos_ff   <= '0;
         len_ff   <= '0;
         bound_ff <= '0;
      end else if (accept) begin
         ctl_ff   <= ctl_in;
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         bound_ff <= bound_in;
      end
   end

`ifndef SYNTHESIS
   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_OK |-> rsp_item.value == 16'd0)
      else $error("error result with nonzero value");
   a_pos_in_token: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= len_ff)
      else $error("character position beyond token length");
   a_skip_needs_token: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.skip_rest |-> ctl_ff.phase != PH_IDLE)
      else $error("skip set with no token open");
   a_idle_at_origin: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.phase == PH_IDLE |-> (pos_ff == '0 && acc_ff == 16'd0))
      else $error("parser state moved while no token open");
`endif

endmodule
